FILE: rtl/segmented_stack_set_top_defines.svh
// assertion macros for the checker file of the segmented stack set
// depends on nothing; taken in by `include where assertions are written
`ifndef SEGMENTED_STACK_SET_TOP_DEFINES_SVH
`define SEGMENTED_STACK_SET_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sss: same-cycle property failed");

// next-cycle implication, reset masks the check
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sss: next-cycle property failed");

`endif

FILE: rtl/sss_pkg.sv
// shared types, codes and defaults of the segmented stack set
// no dependencies; used by every rtl module through scoped names
package sss_pkg;

  // default sizes
  localparam int MAX_STACKS_DEF   = 16;
  localparam int MAX_CAPACITY_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 32;

  // capacity register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_POPAT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADINDEX  = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] push_value;
    logic [3:0]         stack_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         stack_count;
    logic signed [31:0] top_value;
    logic               top_valid;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DROP,
    S_TOP,
    S_DONE
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take;
    logic       sel_idx;
    logic       push_new;
    logic       push_app;
    logic       drop;
    logic       pop;
    logic       set_status;
    logic [1:0] status;
    logic       top_rd;
    logic       load_out;
  } dp_cmd_t;

  // flags from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       fill_zero;
    logic       fill_ge_cap;
    logic       idx_bad;
    logic       idx_zero;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: rtl/sss_ctrl.sv
// sequencing state machine of the segmented stack set
// depends on sss_pkg; drives sss_dp through dp_cmd_t, reads dp_stat_t
module sss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sss_pkg::dp_stat_t  stat,
  output sss_pkg::dp_cmd_t   cmd
);

  sss_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      sss_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sss_pkg::S_EXEC;
        end
      end
      sss_pkg::S_EXEC: begin
        state_nxt = sss_pkg::S_TOP;
        case (stat.op)
          sss_pkg::OP_PUSH: begin
            if (stat.cnt_zero || stat.fill_ge_cap) begin
              if (stat.cnt_full) begin
                cmd.set_status = 1'b1;
                cmd.status     = sss_pkg::ST_OVERFLOW;
              end else begin
                cmd.push_new = 1'b1;
              end
            end else begin
              cmd.push_app = 1'b1;
            end
          end
          sss_pkg::OP_POP: begin
            if (stat.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = sss_pkg::ST_UNDERFLOW;
            end else if (stat.fill_zero) begin
              // last sub-stack empty: drop it, retry on the one before
              cmd.drop  = 1'b1;
              state_nxt = sss_pkg::S_DROP;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          sss_pkg::OP_POPAT: begin
            cmd.sel_idx = 1'b1;
            if (stat.idx_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = sss_pkg::ST_BADINDEX;
            end else if (stat.idx_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = sss_pkg::ST_UNDERFLOW;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      sss_pkg::S_DROP: begin
        state_nxt = sss_pkg::S_TOP;
        if (stat.cnt_zero || stat.fill_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = sss_pkg::ST_UNDERFLOW;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      sss_pkg::S_TOP: begin
        cmd.top_rd = 1'b1;
        state_nxt  = sss_pkg::S_DONE;
      end
      sss_pkg::S_DONE: begin
        // result leaves once the output register is free; next item may enter
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          in_stall     = 1'b0;
          if (in_valid) begin
            cmd.take  = 1'b1;
            state_nxt = sss_pkg::S_EXEC;
          end else begin
            state_nxt = sss_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sss_dp.sv
// datapath of the segmented stack set: fill counters, entry memory, output register
// depends on sss_pkg; commanded by sss_ctrl
module sss_dp #(
  parameter int MAX_STACKS   = sss_pkg::MAX_STACKS_DEF,
  parameter int MAX_CAPACITY = sss_pkg::MAX_CAPACITY_DEF,
  parameter int DATA_WIDTH   = sss_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sss_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sss_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [sss_pkg::CFG_W-1:0] cfg_data,
  input  sss_pkg::dp_cmd_t         cmd,
  output sss_pkg::dp_stat_t        stat
);

  localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int NW    = $clog2(MAX_STACKS + 1);
  localparam int FW    = $clog2(MAX_CAPACITY + 1);
  localparam int DEPTH = MAX_STACKS * MAX_CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // control state
  logic [sss_pkg::CFG_W-1:0] cap_r;
  logic [NW-1:0]             cnt_r;
  logic [FW-1:0]             fill_r [MAX_STACKS];
  logic                      out_valid_r;

  // item and result payload
  logic [1:0]            op_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [3:0]            idx_r;
  logic [1:0]            status_r;
  logic                  pend_r;
  logic                  topok_r;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [DATA_WIDTH-1:0] rd_q;
  sss_pkg::out_item_t    out_r;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [63:0]           in_wide;
  logic [63:0]           pop_wide;
  logic [63:0]           top_wide;
  logic [SW-1:0]         last_s;
  logic [FW-1:0]         fill_last;
  logic [FW-1:0]         fill_idx;
  logic [SW-1:0]         rd_s;
  logic [FW-1:0]         fill_rd;
  logic [FW-1:0]         eff_cap;
  logic                  top_ok;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  fw_en;
  logic [SW-1:0]         fw_s;
  logic [FW-1:0]         fw_v;
  int unsigned           cap_i;

  assign cfg_ready = 1'b1;
  assign in_wide   = {32'd0, in_data.push_value};

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sss_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // effective capacity, clamped to 1..MAX_CAPACITY
  always_comb begin
    cap_i = 32'(cap_r);
    if (cap_i == 0) begin
      cap_i = 1;
    end
    if (cap_i > MAX_CAPACITY) begin
      cap_i = MAX_CAPACITY;
    end
    eff_cap = FW'(cap_i);
  end

  // fill counts of the last sub-stack and of the indexed one
  always_comb begin
    last_s    = SW'(cnt_r - NW'(1));
    fill_last = '0;
    if (32'(last_s) < MAX_STACKS) begin
      fill_last = fill_r[last_s];
    end
    fill_idx = '0;
    if (32'(idx_r) < MAX_STACKS) begin
      fill_idx = fill_r[SW'(idx_r)];
    end
  end

  // sub-stack selected for the memory access and fill update
  always_comb begin
    rd_s    = cmd.sel_idx ? SW'(idx_r) : last_s;
    fill_rd = cmd.sel_idx ? fill_idx : fill_last;
  end

  // flags for the controller
  always_comb begin
    stat.op          = op_r;
    stat.cnt_zero    = (cnt_r == '0);
    stat.cnt_full    = (32'(cnt_r) >= MAX_STACKS);
    stat.fill_zero   = (fill_last == '0);
    stat.fill_ge_cap = (fill_last >= eff_cap);
    stat.idx_bad     = (32'(idx_r) >= 32'(cnt_r));
    stat.idx_zero    = (fill_idx == '0);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // memory and fill counter write and read selection
  always_comb begin
    top_ok  = (cnt_r != '0) && (fill_rd != '0);
    rd_en   = cmd.pop || (cmd.top_rd && top_ok);
    rd_addr = AW'(AW'(rd_s) * AW'(MAX_CAPACITY) + AW'(fill_rd - FW'(1)));
    wr_en   = cmd.push_new || cmd.push_app;
    if (cmd.push_new) begin
      wr_addr = AW'(AW'(SW'(cnt_r)) * AW'(MAX_CAPACITY));
    end else begin
      wr_addr = AW'(AW'(rd_s) * AW'(MAX_CAPACITY) + AW'(fill_rd));
    end
    fw_en = cmd.push_new || cmd.push_app || cmd.pop;
    fw_s  = cmd.push_new ? SW'(cnt_r) : rd_s;
    if (cmd.push_new) begin
      fw_v = FW'(1);
    end else if (cmd.push_app) begin
      fw_v = fill_rd + FW'(1);
    end else begin
      fw_v = fill_rd - FW'(1);
    end
  end

  // fill counters and sub-stack count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (fw_en) begin
        fill_r[fw_s] <= fw_v;
      end
      if (cmd.push_new) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (cmd.drop) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // item latch and per-item result state
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r     <= in_data.opcode;
      val_r    <= in_wide[DATA_WIDTH-1:0];
      idx_r    <= in_data.stack_index;
      status_r <= sss_pkg::ST_OK;
      pend_r   <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.pop) begin
        pend_r <= 1'b1;
      end
    end
    // popped data arrives the cycle after the pop read
    if (cmd.top_rd) begin
      popped_r <= pend_r ? rd_q : '0;
      topok_r  <= top_ok;
    end
  end

  assign pop_wide = 64'(popped_r);
  assign top_wide = 64'(rd_q);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.popped_value <= pop_wide[31:0];
      out_r.status       <= status_r;
      out_r.stack_count  <= 5'(cnt_r);
      out_r.top_value    <= topok_r ? top_wide[31:0] : 32'd0;
      out_r.top_valid    <= topok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/segmented_stack_set_top.sv
// segmented stack set: item accepted in idle or as a result is handed over;
// one item at a time, through execute (with the pop read), drop (only when a pop finds the
// last sub-stack empty; the pop read then follows there), new-top read and result load;
// a stalled result holds the next item back until it leaves
// reset (synchronous, rst_n low) clears the sub-stack count, all fill counts, the
// capacity register (to 16) and the output valid; the entry memory is left as is
module segmented_stack_set_top #(
  parameter int MAX_STACKS   = sss_pkg::MAX_STACKS_DEF,
  parameter int MAX_CAPACITY = sss_pkg::MAX_CAPACITY_DEF,
  parameter int DATA_WIDTH   = sss_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sss_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sss_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sss_pkg::CFG_W-1:0] cfg_data
);

  sss_pkg::dp_cmd_t  cmd;
  sss_pkg::dp_stat_t stat;

  // sequencer
  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, storage and result register
  sss_dp #(
    .MAX_STACKS   (MAX_STACKS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: rtl/sss_chk.sv
// port-level checker of the segmented stack set, bound to the top level
// depends on sss_pkg and segmented_stack_set_top_defines.svh
`include "segmented_stack_set_top_defines.svh"

module sss_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sss_pkg::out_item_t out_data
);

  // a stalled result holds
  `SSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: stall follows every input transfer
  `SSS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

  // a failed operation never reports a popped value
  `SSS_ASSERT_IMPL(a_err_no_pop, clk, rst_n, out_valid && out_data.status != sss_pkg::ST_OK, out_data.popped_value == 32'sd0)

  // a valid top needs a sub-stack, an invalid top reads zero
  `SSS_ASSERT_IMPL(a_top_cons, clk, rst_n, out_valid, out_data.top_valid ? (out_data.stack_count != 5'd0) : (out_data.top_value == 32'sd0))

endmodule

bind segmented_stack_set_top sss_chk u_sss_chk (.*);
